### hw/rtl/rte_pkg.sv
// Shared constants, types and helper functions of the rotation to Euler angles block.
package rte_pkg;

  localparam int ZW          = 33;          // angle accumulator, 2^-23 degree units
  localparam int GUARD_SH    = 12;          // operands scaled by 2^12
  localparam int TABLE_LEN   = 24;
  localparam int INV_GAIN    = 39797;       // inverse CORDIC gain, Q0.16
  localparam int SY_SHIFT    = 28;
  localparam int THR_WIDTH   = 15;
  localparam int ANGLE_WIDTH = 16;

  typedef logic signed [ZW-1:0] ang_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  localparam ang_t DEG90       = ang_t'(754974720);
  localparam ang_t ROUND_HALF  = ang_t'(32768);
  localparam ang_t ANGLE_LIMIT = ang_t'(23040);

  // Arctangent of 2^-i in 2^-23 degree units.
  function automatic ang_t atan_step(int i);
    ang_t v;
    case (i)
      0:       v = ang_t'(377487360);
      1:       v = ang_t'(222843801);
      2:       v = ang_t'(117744544);
      3:       v = ang_t'(59768969);
      4:       v = ang_t'(30000467);
      5:       v = ang_t'(15014858);
      6:       v = ang_t'(7509261);
      7:       v = ang_t'(3754860);
      8:       v = ang_t'(1877459);
      9:       v = ang_t'(938733);
      10:      v = ang_t'(469367);
      11:      v = ang_t'(234684);
      12:      v = ang_t'(117342);
      13:      v = ang_t'(58671);
      14:      v = ang_t'(29335);
      15:      v = ang_t'(14668);
      16:      v = ang_t'(7334);
      17:      v = ang_t'(3667);
      18:      v = ang_t'(1833);
      19:      v = ang_t'(917);
      20:      v = ang_t'(458);
      21:      v = ang_t'(229);
      22:      v = ang_t'(115);
      23:      v = ang_t'(57);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up to 1/128 degree and clamp.
  function automatic angle_t angle_out(ang_t z);
    ang_t r;
    r = (z + ROUND_HALF) >>> 16;
    if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
    if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
    return angle_t'(r);
  endfunction

endpackage

### hw/rtl/rte_delay.sv
// Shift line of registers that carries side data alongside the CORDIC chains.
module rte_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) tap_q[k] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

### hw/rtl/rte_cordic_cell.sv
// One vectoring CORDIC iteration, registered.
module rte_cordic_cell #(
  parameter int W    = 32,
  parameter int STEP = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  rte_pkg::ang_t      z_i,
  input  logic               zero_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output rte_pkg::ang_t      z_o,
  output logic               zero_o
);
  import rte_pkg::*;

  logic signed [W-1:0] xs, ys, x_d, y_d;
  ang_t z_d;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (y_i[W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_step(STEP);
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_step(STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      zero_o <= zero_i;
    end
  end

endmodule

### hw/rtl/rte_vec.sv
// Vectoring CORDIC chain: quadrant turn stage followed by a row of iteration cells.
module rte_vec #(
  parameter int IW    = 18,
  parameter int STEPS = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [IW-1:0] y_i,
  input  logic signed [IW-1:0] x_i,
  output rte_pkg::ang_t       ang_o,
  output logic signed [IW+14:0] mag_o
);
  import rte_pkg::*;

  localparam int W = IW + 15;

  logic signed [W-1:0] cx [0:STEPS];
  logic signed [W-1:0] cy [0:STEPS];
  ang_t                cz [0:STEPS];
  logic                c0 [0:STEPS];

  logic signed [W-1:0] xg, yg, x_d, y_d;
  ang_t z_d;

  assign xg = W'(x_i) <<< GUARD_SH;
  assign yg = W'(y_i) <<< GUARD_SH;

  // Turn a left half plane vector into the right half plane.
  always_comb begin
    x_d = xg;
    y_d = yg;
    z_d = '0;
    if (xg[W-1]) begin
      if (!yg[W-1]) begin
        x_d = yg;
        y_d = -xg;
        z_d = DEG90;
      end else begin
        x_d = -yg;
        y_d = xg;
        z_d = -DEG90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx[0] <= x_d;
      cy[0] <= y_d;
      cz[0] <= z_d;
      c0[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    rte_cordic_cell #(.W(W), .STEP(g)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .x_i    (cx[g]),
      .y_i    (cy[g]),
      .z_i    (cz[g]),
      .zero_i (c0[g]),
      .x_o    (cx[g+1]),
      .y_o    (cy[g+1]),
      .z_o    (cz[g+1]),
      .zero_o (c0[g+1])
    );
  end

  assign ang_o = c0[STEPS] ? '0 : cz[STEPS];
  assign mag_o = c0[STEPS] ? '0 : cx[STEPS];

endmodule

### hw/rtl/rotation_to_euler_angles.sv
// Top level: rotation matrix entries in, x-y-z Euler angles out.
//
// Input channel in_valid_i/in_ready_o carries the seven used matrix entries,
// signed Q2.14. Output channel out_valid_o/out_ready_i carries angle_x/y/z in
// 1/128 degree steps and is_singular. cfg_we_i writes singular_threshold.
//
// The pipeline holds a first row of CORDIC cells for the sy and x/z angles, a
// gain multiply register, a second row of cells for the y angle and one output
// register. One item is accepted per cycle while in_ready_o is high; each cell
// of the rows is one register.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; it advances again as soon as the result is taken.
// Reset empties the pipeline and sets the threshold to 1.
module rotation_to_euler_angles #(
  parameter int CORDIC_STEPS = 16,
  parameter int ENTRY_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ENTRY_WIDTH-1:0] r00_i,
  input  logic signed [ENTRY_WIDTH-1:0] r10_i,
  input  logic signed [ENTRY_WIDTH-1:0] r20_i,
  input  logic signed [ENTRY_WIDTH-1:0] r21_i,
  input  logic signed [ENTRY_WIDTH-1:0] r22_i,
  input  logic signed [ENTRY_WIDTH-1:0] r12_i,
  input  logic signed [ENTRY_WIDTH-1:0] r11_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rte_pkg::angle_t              angle_x_o,
  output rte_pkg::angle_t              angle_y_o,
  output rte_pkg::angle_t              angle_z_o,
  output logic                         is_singular_o,
  input  logic                         cfg_we_i,
  input  logic [rte_pkg::THR_WIDTH-1:0] cfg_wdata_i
);
  import rte_pkg::*;

  localparam int IW  = ENTRY_WIDTH + 2;
  localparam int MW  = IW + 15;
  localparam int PW  = MW + 16;
  localparam int LAT = CORDIC_STEPS + 1;
  localparam int SW  = 2 * ZW + 1;

  logic adv;
  logic [THR_WIDTH-1:0] thr_q;
  logic vld_pipe;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_WIDTH'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // First row: sy/z from (r00, r10), x from both candidate pairs.
  ang_t az_c, axn_c, axs_c;
  logic signed [MW-1:0] mag_c, mag_b_unused, mag_s_unused;

  rte_vec #(.IW(IW), .STEPS(CORDIC_STEPS)) u_vec_z (
    .clk_i(clk_i), .en_i(adv),
    .y_i(IW'(r10_i)), .x_i(IW'(r00_i)), .ang_o(az_c), .mag_o(mag_c)
  );
  rte_vec #(.IW(IW), .STEPS(CORDIC_STEPS)) u_vec_xn (
    .clk_i(clk_i), .en_i(adv),
    .y_i(IW'(r21_i)), .x_i(IW'(r22_i)), .ang_o(axn_c), .mag_o(mag_b_unused)
  );
  rte_vec #(.IW(IW), .STEPS(CORDIC_STEPS)) u_vec_xs (
    .clk_i(clk_i), .en_i(adv),
    .y_i(-IW'(r12_i)), .x_i(IW'(r11_i)), .ang_o(axs_c), .mag_o(mag_s_unused)
  );

  logic signed [IW-1:0] nr20_dly;
  rte_delay #(.WIDTH(IW), .DEPTH(LAT + 1)) u_dly_r20 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .d_i(-IW'(r20_i)), .q_o(nr20_dly)
  );

  // Gain correction stage.
  logic [PW-1:0] prod;
  logic [IW-1:0] sy_q;
  ang_t az_q, axn_q, axs_q;

  assign prod = (mag_c[MW-1] ? '0 : PW'(unsigned'(mag_c))) * PW'(INV_GAIN)
              + (PW'(1) << (SY_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sy_q  <= IW'(prod >> SY_SHIFT);
      az_q  <= az_c;
      axn_q <= axn_c;
      axs_q <= axs_c;
    end
  end

  logic sing;
  ang_t ax_sel;
  assign sing   = sy_q < IW'(thr_q);
  assign ax_sel = sing ? axs_q : axn_q;

  // Second row: y from (-r20, sy).
  ang_t ay_c;
  logic signed [MW-1:0] mag_y_unused;
  rte_vec #(.IW(IW), .STEPS(CORDIC_STEPS)) u_vec_y (
    .clk_i(clk_i), .en_i(adv),
    .y_i(nr20_dly), .x_i(signed'(sy_q)), .ang_o(ay_c), .mag_o(mag_y_unused)
  );

  logic [SW-1:0] side_dly;
  rte_delay #(.WIDTH(SW), .DEPTH(LAT)) u_dly_side (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .d_i({sing, ax_sel, az_q}), .q_o(side_dly)
  );

  rte_delay #(.WIDTH(1), .DEPTH(2 * LAT + 1)) u_dly_vld (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .d_i(in_valid_i), .q_o(vld_pipe)
  );

  logic out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_pipe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_x_o     <= angle_out(side_dly[2*ZW-1:ZW]);
      angle_y_o     <= angle_out(ay_c);
      angle_z_o     <= side_dly[SW-1] ? '0 : angle_out(side_dly[ZW-1:0]);
      is_singular_o <= side_dly[SW-1];
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

### hw/rtl/rte_checker.sv
// Port-level checks of the rotation to Euler angles block, bound to the top level.
module rte_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input rte_pkg::angle_t         angle_x_o,
  input rte_pkg::angle_t         angle_z_o,
  input logic                    is_singular_o
);
  import rte_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(angle_x_o) && $stable(is_singular_o))
    else $error("result changed while stalled");

  a_sing_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_singular_o |-> angle_z_o == '0)
    else $error("singular result with nonzero z angle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_x_o <= 16'sd23040) && (angle_x_o >= -16'sd23040))
    else $error("x angle outside clamp range");

endmodule

bind rotation_to_euler_angles rte_checker u_rte_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .angle_x_o(angle_x_o), .angle_z_o(angle_z_o), .is_singular_o(is_singular_o)
);
